[hdl/cbmirq_pkg.sv]
// Shared constants and helpers for the cartridge bank mapper with IRQ unit.
// Item kind codes, register reset values and the PRG mask table.
// No dependencies.
package cbmirq_pkg;

    // item kind codes
    localparam logic [2:0] KIND_CPU_WRITE  = 3'd0;
    localparam logic [2:0] KIND_CPU_TICK   = 3'd1;
    localparam logic [2:0] KIND_A12_RISE   = 3'd2;
    localparam logic [2:0] KIND_CPU_XLATE  = 3'd3;
    localparam logic [2:0] KIND_PPU_XLATE  = 3'd4;

    // CPU register window codes (address bits 15:12)
    localparam logic [3:0] WIN_PRG   = 4'h8;
    localparam logic [3:0] WIN_OUTER = 4'h9;
    localparam logic [3:0] WIN_CHR_A = 4'hA;
    localparam logic [3:0] WIN_CHR_B = 4'hB;
    localparam logic [3:0] WIN_IRQ   = 4'hC;

    // register select within a window (address bits 1:0)
    localparam logic [1:0] SEL_0 = 2'd0;
    localparam logic [1:0] SEL_1 = 2'd1;
    localparam logic [1:0] SEL_2 = 2'd2;
    localparam logic [1:0] SEL_3 = 2'd3;

    // CPU window code from address bits 15:13
    localparam logic [2:0] CPU_WIN_WRAM = 3'd3;
    localparam logic [2:0] CPU_WIN_LAST = 3'd7;

    // A12 filter hold-off, in CPU cycle ticks
    localparam int A12_FILTER_CYCLES = 5;
    localparam logic [2:0] A12_FILTER_LOAD = 3'(A12_FILTER_CYCLES & 7);

    // reset values
    localparam logic [7:0] PRG0_RESET      = 8'hFC;
    localparam logic [7:0] PRG1_RESET      = 8'hFD;
    localparam logic [7:0] PRG2_RESET      = 8'hFE;
    localparam logic [7:0] PRG3_RESET      = 8'hFF;
    localparam logic [7:0] PRG_MASK_RESET  = 8'h3F;
    localparam logic [7:0] CHR_MASK_RESET  = 8'hFF;
    localparam logic [7:0] CHR_MASK_FULL   = 8'hFF;
    localparam logic [7:0] CHR_MASK_HALF   = 8'h7F;
    localparam logic [7:0] LAST_PRG_BANK   = 8'hFF;

    typedef logic [7:0] byte_t;

    // PRG mask selected by the low two bits of a mask write
    function automatic byte_t prg_mask_of(input logic [1:0] sel);
        byte_t m;
        unique case (sel)
            SEL_0: m = 8'h3F;
            SEL_1: m = 8'h1F;
            SEL_2: m = 8'h2F;
            SEL_3: m = 8'h0F;
        endcase
        return m;
    endfunction

    // raw CHR register used for each 2k window
    function automatic logic [2:0] chr_2k_pick(input logic [1:0] win);
        logic [2:0] r;
        unique case (win)
            SEL_0: r = 3'd0;
            SEL_1: r = 3'd1;
            SEL_2: r = 3'd6;
            SEL_3: r = 3'd7;
        endcase
        return r;
    endfunction

endpackage

[hdl/cartridge_bank_mapper_with_irq_core.sv]
// Top level of the cartridge bank mapper: bank registers, IRQ unit, translation.
// Uses cbmirq_pkg for kind codes, reset values and the mask tables.
//
//  channel  direction  signals                                 word
//  in       sink       in_valid in_ready kind address data     one bus event
//  out      source     out_valid out_ready bank bank_valid     one result
//                      irq_line mirroring
//  cfg      sink       cfg_valid cfg_ready cfg_data            chr_2k_mode
//
// One word per clock while results are taken; a word passes the input register, then the result register.
// State updates as the result register loads, so back-to-back words see each
// other's effects with no bubble.
// A stalled result holds in_ready low, combinationally, once the input register is full.
// Reset is asynchronous and active low; cfg_ready is always high.
module cartridge_bank_mapper_with_irq_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [14:0] bank,
    output logic        bank_valid,
    output logic        irq_line,
    output logic [1:0]  mirroring,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    // input register
    logic        item_vld_reg;
    logic        item_vld_next;
    logic [2:0]  item_kind_reg;
    logic [15:0] item_addr_reg;
    logic [7:0]  item_data_reg;

    // mapper state
    logic [7:0]  prg_reg [4];
    logic [7:0]  prg_next [4];
    logic [7:0]  chr_reg [8];
    logic [7:0]  chr_next [8];
    logic [7:0]  outer_base_reg, outer_base_next;
    logic [7:0]  prg_mask_reg, prg_mask_next;
    logic [7:0]  chr_base_reg, chr_base_next;
    logic [7:0]  chr_mask_reg, chr_mask_next;
    logic [1:0]  mirror_reg, mirror_next;
    logic [7:0]  cnt_lo_reg, cnt_lo_next;
    logic [7:0]  cnt_hi_reg, cnt_hi_next;
    logic        irq_enable_reg, irq_enable_next;
    logic        irq_mode_reg, irq_mode_next;
    logic        irq_auto_reg, irq_auto_next;
    logic        irq_reload_reg, irq_reload_next;
    logic [2:0]  filter_reg, filter_next;
    logic        pending_reg, pending_next;
    logic        chr_2k_reg;

    // result register
    logic        res_vld_reg;
    logic        res_vld_next;
    logic [14:0] res_bank_reg;
    logic        res_hit_reg;
    logic        res_irq_reg;
    logic [1:0]  res_mirror_reg;

    // translation
    logic [14:0] xl_bank;
    logic        xl_hit;
    logic [7:0]  prg_sel;
    logic [2:0]  chr_idx;
    logic [7:0]  chr_sel;
    logic [15:0] cnt_dec;
    logic [7:0]  lo_new;
    logic        proc;

    // handshake: a word moves on when the result register is free or drains
    assign proc          = item_vld_reg && (!res_vld_reg || out_ready);
    assign in_ready      = !item_vld_reg || proc;
    assign cfg_ready     = 1'b1;
    assign item_vld_next = (in_valid && in_ready) ? 1'b1 : (proc ? 1'b0 : item_vld_reg);
    assign res_vld_next  = proc ? 1'b1 : (out_ready ? 1'b0 : res_vld_reg);

    assign out_valid  = res_vld_reg;
    assign bank       = res_bank_reg;
    assign bank_valid = res_hit_reg;
    assign irq_line   = res_irq_reg;
    assign mirroring  = res_mirror_reg;

    // pick the PRG register for the CPU window
    always_comb
    begin
        if (item_addr_reg[15:13] == cbmirq_pkg::CPU_WIN_WRAM)
            prg_sel = prg_reg[3];
        else if (item_addr_reg[15:13] == cbmirq_pkg::CPU_WIN_LAST)
            prg_sel = cbmirq_pkg::LAST_PRG_BANK;
        else
            prg_sel = prg_reg[item_addr_reg[14:13]];
    end

    // pick the CHR register: one read port, index depends on the variant
    assign chr_idx = chr_2k_reg ? cbmirq_pkg::chr_2k_pick(item_addr_reg[12:11])
                                : item_addr_reg[12:10];
    assign chr_sel = chr_reg[chr_idx];

    // translate the query; misses give bank zero
    always_comb
    begin
        xl_bank = '0;
        xl_hit  = 1'b0;
        if (item_kind_reg == cbmirq_pkg::KIND_CPU_XLATE)
        begin
            if (item_addr_reg[15:13] >= cbmirq_pkg::CPU_WIN_WRAM)
            begin
                xl_hit  = 1'b1;
                xl_bank = {7'd0, ({1'b0, outer_base_reg[5:3], 4'd0} | (prg_sel & prg_mask_reg))};
            end
        end
        else if (item_kind_reg == cbmirq_pkg::KIND_PPU_XLATE)
        begin
            if (item_addr_reg[15:13] == 3'd0)
            begin
                xl_hit = 1'b1;
                if (chr_2k_reg)
                    xl_bank = {7'd0, chr_sel};
                else
                    xl_bank = {chr_base_reg, 7'd0} | {7'd0, chr_sel & chr_mask_reg};
            end
        end
    end

    assign cnt_dec = {cnt_hi_reg, cnt_lo_reg} - 16'd1;
    assign lo_new  = ((cnt_lo_reg == 8'd0) || irq_reload_reg) ? cnt_hi_reg
                                                              : (cnt_lo_reg - 8'd1);

    // apply the word to the mapper state
    always_comb
    begin
        prg_next        = prg_reg;
        chr_next        = chr_reg;
        outer_base_next = outer_base_reg;
        prg_mask_next   = prg_mask_reg;
        chr_base_next   = chr_base_reg;
        chr_mask_next   = chr_mask_reg;
        mirror_next     = mirror_reg;
        cnt_lo_next     = cnt_lo_reg;
        cnt_hi_next     = cnt_hi_reg;
        irq_enable_next = irq_enable_reg;
        irq_mode_next   = irq_mode_reg;
        irq_auto_next   = irq_auto_reg;
        irq_reload_next = irq_reload_reg;
        filter_next     = filter_reg;
        pending_next    = pending_reg;
        unique case (item_kind_reg)
            cbmirq_pkg::KIND_CPU_WRITE:
            begin
                unique case (item_addr_reg[15:12])
                    cbmirq_pkg::WIN_PRG:
                        prg_next[item_addr_reg[1:0]] = item_data_reg;
                    cbmirq_pkg::WIN_OUTER:
                    begin
                        unique case (item_addr_reg[1:0])
                            cbmirq_pkg::SEL_0: outer_base_next = item_data_reg;
                            cbmirq_pkg::SEL_1:
                            begin
                                prg_mask_next = cbmirq_pkg::prg_mask_of(item_data_reg[1:0]);
                                chr_mask_next = item_data_reg[6] ? cbmirq_pkg::CHR_MASK_FULL
                                                                 : cbmirq_pkg::CHR_MASK_HALF;
                            end
                            cbmirq_pkg::SEL_2: mirror_next = item_data_reg[1:0];
                            cbmirq_pkg::SEL_3: chr_base_next = item_data_reg;
                        endcase
                    end
                    cbmirq_pkg::WIN_CHR_A, cbmirq_pkg::WIN_CHR_B:
                        chr_next[{item_addr_reg[12], item_addr_reg[1:0]}] = item_data_reg;
                    cbmirq_pkg::WIN_IRQ:
                    begin
                        unique case (item_addr_reg[1:0])
                            cbmirq_pkg::SEL_0:
                            begin
                                if (irq_auto_reg)
                                    irq_enable_next = 1'b0;
                                cnt_lo_next = item_data_reg;
                            end
                            cbmirq_pkg::SEL_1:
                            begin
                                if (irq_auto_reg)
                                    irq_enable_next = 1'b1;
                                cnt_hi_next     = item_data_reg;
                                irq_reload_next = 1'b1;
                            end
                            cbmirq_pkg::SEL_2:
                            begin
                                irq_enable_next = item_data_reg[0];
                                irq_mode_next   = item_data_reg[1];
                                irq_auto_next   = item_data_reg[2];
                            end
                            cbmirq_pkg::SEL_3:
                                irq_enable_next = item_data_reg[0];
                        endcase
                        pending_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            cbmirq_pkg::KIND_CPU_TICK:
            begin
                if (filter_reg != 3'd0)
                    filter_next = filter_reg - 3'd1;
                if (irq_enable_reg && !irq_mode_reg && ({cnt_hi_reg, cnt_lo_reg} != 16'd0))
                begin
                    cnt_hi_next = cnt_dec[15:8];
                    cnt_lo_next = cnt_dec[7:0];
                    if (cnt_dec == 16'd0)
                        pending_next = 1'b1;
                end
            end
            cbmirq_pkg::KIND_A12_RISE:
            begin
                if ((filter_reg == 3'd0) && irq_mode_reg)
                begin
                    cnt_lo_next = lo_new;
                    if ((lo_new == 8'd0) && irq_enable_reg)
                        pending_next = 1'b1;
                    irq_reload_next = 1'b0;
                end
                filter_next = cbmirq_pkg::A12_FILTER_LOAD;
            end
            default:
            begin
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg   <= 1'b0;
            res_vld_reg    <= 1'b0;
            prg_reg[0]     <= cbmirq_pkg::PRG0_RESET;
            prg_reg[1]     <= cbmirq_pkg::PRG1_RESET;
            prg_reg[2]     <= cbmirq_pkg::PRG2_RESET;
            prg_reg[3]     <= cbmirq_pkg::PRG3_RESET;
            for (int i = 0; i < 8; i++)
                chr_reg[i] <= 8'(i);
            outer_base_reg <= '0;
            prg_mask_reg   <= cbmirq_pkg::PRG_MASK_RESET;
            chr_base_reg   <= '0;
            chr_mask_reg   <= cbmirq_pkg::CHR_MASK_RESET;
            mirror_reg     <= '0;
            cnt_lo_reg     <= '0;
            cnt_hi_reg     <= '0;
            irq_enable_reg <= 1'b0;
            irq_mode_reg   <= 1'b0;
            irq_auto_reg   <= 1'b0;
            irq_reload_reg <= 1'b0;
            filter_reg     <= '0;
            pending_reg    <= 1'b0;
            chr_2k_reg     <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            res_vld_reg  <= res_vld_next;
            if (cfg_valid && cfg_ready)
                chr_2k_reg <= cfg_data;
            // advance the state only when the word moves into the result register
            if (proc)
            begin
                prg_reg        <= prg_next;
                chr_reg        <= chr_next;
                outer_base_reg <= outer_base_next;
                prg_mask_reg   <= prg_mask_next;
                chr_base_reg   <= chr_base_next;
                chr_mask_reg   <= chr_mask_next;
                mirror_reg     <= mirror_next;
                cnt_lo_reg     <= cnt_lo_next;
                cnt_hi_reg     <= cnt_hi_next;
                irq_enable_reg <= irq_enable_next;
                irq_mode_reg   <= irq_mode_next;
                irq_auto_reg   <= irq_auto_next;
                irq_reload_reg <= irq_reload_next;
                filter_reg     <= filter_next;
                pending_reg    <= pending_next;
            end
        end
    end

    // payload registers: capture on accept, load result on advance
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_kind_reg <= kind;
            item_addr_reg <= address;
            item_data_reg <= data;
        end
        if (proc)
        begin
            res_bank_reg   <= xl_bank;
            res_hit_reg    <= xl_hit;
            res_irq_reg    <= pending_next;
            res_mirror_reg <= mirror_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a miss or a non-translate word always reports bank zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bank_valid) |-> (bank == 15'd0))
        else $error("bank nonzero on a miss");

    // the A12 filter never holds more than its load value
    a_filter_range: assert property (@(posedge clk) disable iff (!rst_n)
        filter_reg <= cbmirq_pkg::A12_FILTER_LOAD)
        else $error("A12 filter out of range");

    // a waiting result reports the live IRQ state
    a_irq_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (irq_line == pending_reg))
        else $error("result IRQ differs from pending state");

    // pending clears only through an IRQ register write
    a_pending_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(pending_reg) |-> ($past(proc)
            && ($past(item_kind_reg) == cbmirq_pkg::KIND_CPU_WRITE)
            && ($past(item_addr_reg[15:12]) == cbmirq_pkg::WIN_IRQ)))
        else $error("IRQ pending cleared without an IRQ write");

    // input stalls only while a word is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (item_vld_reg && res_vld_reg && !out_ready))
        else $error("input stalled with nothing held");
`endif

endmodule
